// File: sv/dqsw_pkg.sv
// Package for the DNS question-section walker.
// Holds the parse phase type, the result record and header layout constants.
// No dependencies.
package dqsw_pkg;

   // Fixed DNS header size and the position of the question count in it
   localparam int unsigned HEADER_BYTES = 12;
   localparam logic [15:0] HDR_LAST_POS = 16'(HEADER_BYTES - 1);
   localparam logic [15:0] QDCOUNT_HI_POS = 16'd4;
   localparam logic [15:0] QDCOUNT_LO_POS = 16'd5;

   // Classes 1..4 (IN, CS, CH, HS) count as known
   localparam logic [15:0] CLASS_LIMIT = 16'd5;

   // Stream widths
   localparam int unsigned REQ_DATA_BITS = 8;
   localparam int unsigned RSP_DATA_BITS = 88;

   // Result kinds
   localparam logic KIND_QUESTION = 1'b0;
   localparam logic KIND_EMPTY = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_LABEL_LEN,
      PH_LABEL_BODY,
      PH_FIXED,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] question_index;
      logic [15:0] start_offset;
      logic [15:0] end_offset;
      logic [15:0] query_type;
      logic [15:0] query_class;
      logic        type_nonzero;
      logic        class_known;
      logic        last_question;
   } rsp_item_type;

endpackage

// File: sv/dns_question_section_walker.sv
// Output: a result is registered and becomes valid in the cycle after the byte that completes it.
// Throughput: one message byte per cycle; a result that waits on a low rsp_tready stops
// input until the downstream takes it, and a new byte is taken in the cycle it is taken.
// Reset: synchronous, active high; the walker returns to idle and waits for a
// byte flagged as message start. All walk state and the output valid are cleared.
// Top level of the DNS question-section walker; depends on dqsw_pkg.
module dns_question_section_walker
   import dqsw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // input stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // [7:0] data_byte
   input  logic                     req_tuser,  // [0] message_start
   // result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // [15:0] question_index,
                                                // [31:16] start_offset,
                                                // [47:32] end_offset,
                                                // [63:48] query_type,
                                                // [79:64] query_class,
                                                // [80] type_nonzero,
                                                // [81] class_known, [87:82] zero
   output logic                     rsp_tuser,  // [0] result_kind
   output logic                     rsp_tlast   // last_question
);

   // walk state
   phase_type    phase_ff, phase_in;
   logic [15:0]  offset_ff, offset_in;
   logic [7:0]   label_left_ff, label_left_in;
   logic [15:0]  q_expected_ff, q_expected_in;
   logic [15:0]  q_done_ff, q_done_in;
   logic [15:0]  q_start_ff, q_start_in;
   logic [23:0]  fixed_shift_ff, fixed_shift_in;
   logic [1:0]   fixed_cnt_ff, fixed_cnt_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // state seen by the current byte (a start restarts the walk)
   phase_type    cur_phase;
   logic [15:0]  cur_offset;
   logic [7:0]   cur_label_left;
   logic [15:0]  cur_q_expected;
   logic [15:0]  cur_q_done;
   logic [15:0]  cur_q_start;
   logic [23:0]  cur_fixed_shift;
   logic [1:0]   cur_fixed_cnt;

   logic         req_accept;
   logic         emit;
   logic [7:0]   data_byte;
   logic [31:0]  fixed_full;
   logic [15:0]  qtype;
   logic [15:0]  qclass;
   logic         last_q;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign data_byte  = req_tdata[7:0];

   assign fixed_full = {cur_fixed_shift, data_byte};
   assign qtype      = fixed_full[31:16];
   assign qclass     = fixed_full[15:0];
   assign last_q     = (cur_q_done + 16'd1) == cur_q_expected;

   // restart view
   always_comb begin
      if (req_tuser) begin
         cur_phase       = PH_HEADER;
         cur_offset      = '0;
         cur_label_left  = '0;
         cur_q_expected  = '0;
         cur_q_done      = '0;
         cur_q_start     = '0;
         cur_fixed_shift = '0;
         cur_fixed_cnt   = '0;
      end else begin
         cur_phase       = phase_ff;
         cur_offset      = offset_ff;
         cur_label_left  = label_left_ff;
         cur_q_expected  = q_expected_ff;
         cur_q_done      = q_done_ff;
         cur_q_start     = q_start_ff;
         cur_fixed_shift = fixed_shift_ff;
         cur_fixed_cnt   = fixed_cnt_ff;
      end
   end

   // per-byte walk step
   always_comb begin
      phase_in       = phase_ff;
      offset_in      = offset_ff;
      label_left_in  = label_left_ff;
      q_expected_in  = q_expected_ff;
      q_done_in      = q_done_ff;
      q_start_in     = q_start_ff;
      fixed_shift_in = fixed_shift_ff;
      fixed_cnt_in   = fixed_cnt_ff;
      emit           = 1'b0;
      rsp_item_in    = '0;

      if (req_accept) begin
         phase_in       = cur_phase;
         offset_in      = cur_offset;
         label_left_in  = cur_label_left;
         q_expected_in  = cur_q_expected;
         q_done_in      = cur_q_done;
         q_start_in     = cur_q_start;
         fixed_shift_in = cur_fixed_shift;
         fixed_cnt_in   = cur_fixed_cnt;

         if (cur_phase != PH_IDLE && cur_phase != PH_DONE) begin
            // saturating byte position
            offset_in = (cur_offset == 16'hFFFF) ? cur_offset : cur_offset + 16'd1;

            case (cur_phase)
               PH_HEADER: begin
                  if (cur_offset == QDCOUNT_HI_POS) begin
                     q_expected_in[15:8] = data_byte;
                  end else if (cur_offset == QDCOUNT_LO_POS) begin
                     q_expected_in[7:0] = data_byte;
                  end
                  if (cur_offset == HDR_LAST_POS) begin
                     q_start_in = offset_in;
                     if (cur_q_expected == 16'd0) begin
                        // empty question section
                        phase_in                   = PH_DONE;
                        emit                       = 1'b1;
                        rsp_item_in.result_kind    = KIND_EMPTY;
                        rsp_item_in.start_offset   = 16'(HEADER_BYTES);
                        rsp_item_in.end_offset     = 16'(HEADER_BYTES);
                        rsp_item_in.last_question  = 1'b1;
                     end else begin
                        phase_in = PH_LABEL_LEN;
                     end
                  end
               end
               PH_LABEL_LEN: begin
                  if (data_byte == 8'd0) begin
                     phase_in       = PH_FIXED;
                     fixed_cnt_in   = '0;
                     fixed_shift_in = '0;
                  end else begin
                     label_left_in = data_byte;
                     phase_in      = PH_LABEL_BODY;
                  end
               end
               PH_LABEL_BODY: begin
                  label_left_in = cur_label_left - 8'd1;
                  if (cur_label_left == 8'd1) begin
                     phase_in = PH_LABEL_LEN;
                  end
               end
               PH_FIXED: begin
                  // type and class bytes, big-endian
                  fixed_shift_in = fixed_full[23:0];
                  if (cur_fixed_cnt != 2'd3) begin
                     fixed_cnt_in = cur_fixed_cnt + 2'd1;
                  end else begin
                     fixed_cnt_in               = '0;
                     emit                       = 1'b1;
                     rsp_item_in.result_kind    = KIND_QUESTION;
                     rsp_item_in.question_index = cur_q_done;
                     rsp_item_in.start_offset   = cur_q_start;
                     rsp_item_in.end_offset     = offset_in;
                     rsp_item_in.query_type     = qtype;
                     rsp_item_in.query_class    = qclass;
                     rsp_item_in.type_nonzero   = (qtype != 16'd0);
                     rsp_item_in.class_known    = (qclass != 16'd0) && (qclass < CLASS_LIMIT);
                     rsp_item_in.last_question  = last_q;
                     q_done_in                  = cur_q_done + 16'd1;
                     if (last_q) begin
                        phase_in = PH_DONE;
                     end else begin
                        q_start_in = offset_in;
                        phase_in   = PH_LABEL_LEN;
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // output valid: set by a new result, cleared once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         offset_ff      <= '0;
         label_left_ff  <= '0;
         q_expected_ff  <= '0;
         q_done_ff      <= '0;
         q_start_ff     <= '0;
         fixed_shift_ff <= '0;
         fixed_cnt_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         offset_ff      <= offset_in;
         label_left_ff  <= label_left_in;
         q_expected_ff  <= q_expected_in;
         q_done_ff      <= q_done_in;
         q_start_ff     <= q_start_in;
         fixed_shift_ff <= fixed_shift_in;
         fixed_cnt_ff   <= fixed_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.result_kind;
   assign rsp_tlast  = rsp_item_ff.last_question;
   assign rsp_tdata  = {6'b0,
                        rsp_item_ff.class_known,
                        rsp_item_ff.type_nonzero,
                        rsp_item_ff.query_class,
                        rsp_item_ff.query_type,
                        rsp_item_ff.end_offset,
                        rsp_item_ff.start_offset,
                        rsp_item_ff.question_index};

   // an empty-section result always closes the section
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.result_kind |-> rsp_item_ff.last_question)
      else $error("empty-section result without last flag");

   // a start byte always lands the walk on header byte 1
   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser |=> phase_ff == PH_HEADER && offset_ff == 16'd1)
      else $error("message start did not restart the walk");

   // inside the question walk fewer questions are done than announced
   a_done_below_expected: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LABEL_LEN || phase_ff == PH_LABEL_BODY || phase_ff == PH_FIXED)
      |-> q_done_ff < q_expected_ff)
      else $error("question count overrun");

   // a label body always has bytes left
   a_label_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LABEL_BODY |-> label_left_ff != 8'd0)
      else $error("label body with no bytes left");

endmodule
